@@ rtl/cbh_pkg.sv @@
`default_nettype none

package cbh_pkg;

    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned IDX_W     = 11;
    localparam int unsigned SYM_W     = 6;
    localparam int unsigned LET_W     = 5;
    localparam int unsigned SEL_W     = 3;
    localparam int unsigned NTBL      = 6;
    localparam int unsigned NSYM_WITH = 33;
    localparam int unsigned NSYM_LET  = 32;

    // longest table, sets the length of the clearing sweep
    localparam int unsigned CLR_LEN = NSYM_WITH * NSYM_WITH;

    localparam logic [SYM_W-1:0] SPACE_CODE = SYM_W'(NSYM_LET);
    localparam logic [LET_W-1:0] YE_CODE    = LET_W'(5);

    localparam logic [7:0] LEAD_D0  = 8'hD0;
    localparam logic [7:0] LEAD_D1  = 8'hD1;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] YO_UPPER = 8'h81;
    localparam logic [7:0] YO_LOWER = 8'h91;

    typedef enum logic {
        OP_FEED = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [SEL_W-1:0] {
        TBL_SINGLE_WITH  = 3'd0,
        TBL_OVL_WITH     = 3'd1,
        TBL_NOVL_WITH    = 3'd2,
        TBL_SINGLE_LET   = 3'd3,
        TBL_OVL_LET      = 3'd4,
        TBL_NOVL_LET     = 3'd5
    } tbl_sel_t;

    localparam int unsigned TBL_DEPTH [NTBL] = '{
        NSYM_WITH, NSYM_WITH * NSYM_WITH, NSYM_WITH * NSYM_WITH,
        NSYM_LET, NSYM_LET * NSYM_LET, NSYM_LET * NSYM_LET
    };

    typedef struct packed {
        logic ok;
        logic [LET_W-1:0] code;
    } letter_t;

    // per-item request into the counter memories
    typedef struct packed {
        logic rd;
        logic rd_ok;
        logic [SEL_W-1:0] sel;
        logic [NTBL-1:0] inc;
        logic [NTBL-1:0][IDX_W-1:0] addr;
    } cnt_req_t;

    function automatic logic [IDX_W:0] tbl_depth(input logic [SEL_W-1:0] sel);
        logic [IDX_W:0] d;
        unique case (sel)
            TBL_SINGLE_WITH: d = (IDX_W+1)'(TBL_DEPTH[0]);
            TBL_OVL_WITH:    d = (IDX_W+1)'(TBL_DEPTH[1]);
            TBL_NOVL_WITH:   d = (IDX_W+1)'(TBL_DEPTH[2]);
            TBL_SINGLE_LET:  d = (IDX_W+1)'(TBL_DEPTH[3]);
            TBL_OVL_LET:     d = (IDX_W+1)'(TBL_DEPTH[4]);
            TBL_NOVL_LET:    d = (IDX_W+1)'(TBL_DEPTH[5]);
            default:         d = '0;
        endcase
        return d;
    endfunction

    // second byte of a two-byte letter, lead 0xD0 or 0xD1
    function automatic letter_t decode_pair(input logic d1, input logic [7:0] b);
        letter_t r;
        logic [7:0] diff;
        diff = b - 8'h90;
        r.ok   = 1'b0;
        r.code = '0;
        if (!d1) begin
            if (b >= 8'h90 && b <= 8'hAF) begin
                r.ok   = 1'b1;
                r.code = diff[LET_W-1:0];
            end else if (b >= 8'hB0 && b <= 8'hBF) begin
                r.ok   = 1'b1;
                r.code = {1'b0, b[3:0]};
            end else if (b == YO_UPPER) begin
                r.ok   = 1'b1;
                r.code = YE_CODE;
            end
        end else begin
            if (b >= 8'h80 && b <= 8'h8F) begin
                r.ok   = 1'b1;
                r.code = {1'b1, b[3:0]};
            end else if (b == YO_LOWER) begin
                r.ok   = 1'b1;
                r.code = YE_CODE;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cbh_ram.sv @@
`default_nettype none

module cbh_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/cbh_decode.sv @@
`default_nettype none

module cbh_decode (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         acc,
    input  wire logic                         op,
    input  wire logic [7:0]                   text_byte,
    input  wire logic [cbh_pkg::SEL_W-1:0]    table_select,
    input  wire logic [cbh_pkg::IDX_W-1:0]    entry_index,
    output cbh_pkg::cnt_req_t                 req
);

    logic                        lead_pending_reg, lead_pending_next;
    logic                        lead_is_d1_reg, lead_is_d1_next;
    logic                        last_was_space_reg, last_was_space_next;
    logic [cbh_pkg::SYM_W-1:0]   prev_with_reg, prev_with_next;
    logic                        prev_with_valid_reg, prev_with_valid_next;
    logic                        par_with_reg, par_with_next;
    logic [cbh_pkg::LET_W-1:0]   prev_letter_reg, prev_letter_next;
    logic                        prev_letter_valid_reg, prev_letter_valid_next;
    logic                        par_let_reg, par_let_next;

    cbh_pkg::letter_t            dec;
    logic                        feed, is_ws, push, is_letter;
    logic [cbh_pkg::SYM_W-1:0]   sym;
    logic [cbh_pkg::IDX_W-1:0]   k_with, k_let;

    assign dec   = cbh_pkg::decode_pair(lead_is_d1_reg, text_byte);
    assign feed  = acc && (op == cbh_pkg::OP_FEED);
    assign is_ws = (text_byte == cbh_pkg::CH_SPACE) || (text_byte == cbh_pkg::CH_TAB)
                || (text_byte == cbh_pkg::CH_LF) || (text_byte == cbh_pkg::CH_CR);

    always_comb begin
        push = 1'b0;
        sym  = cbh_pkg::SPACE_CODE;
        if (lead_pending_reg) begin
            push = dec.ok;
            sym  = {1'b0, dec.code};
        end else if (is_ws) begin
            push = !last_was_space_reg;
        end
    end

    assign is_letter = (sym != cbh_pkg::SPACE_CODE);
    // prev * 33 + sym
    assign k_with = {prev_with_reg, 5'b0} + cbh_pkg::IDX_W'(prev_with_reg)
                  + cbh_pkg::IDX_W'(sym);
    assign k_let  = cbh_pkg::IDX_W'({prev_letter_reg, sym[cbh_pkg::LET_W-1:0]});

    always_comb begin
        lead_pending_next      = lead_pending_reg;
        lead_is_d1_next        = lead_is_d1_reg;
        last_was_space_next    = last_was_space_reg;
        prev_with_next         = prev_with_reg;
        prev_with_valid_next   = prev_with_valid_reg;
        par_with_next          = par_with_reg;
        prev_letter_next       = prev_letter_reg;
        prev_letter_valid_next = prev_letter_valid_reg;
        par_let_next           = par_let_reg;
        if (feed) begin
            if (lead_pending_reg) begin
                lead_pending_next = 1'b0;
            end else if (text_byte == cbh_pkg::LEAD_D0 || text_byte == cbh_pkg::LEAD_D1) begin
                lead_pending_next = 1'b1;
                lead_is_d1_next   = (text_byte == cbh_pkg::LEAD_D1);
            end
            if (push) begin
                last_was_space_next  = !is_letter;
                prev_with_next       = sym;
                prev_with_valid_next = 1'b1;
                par_with_next        = !par_with_reg;
                if (is_letter) begin
                    prev_letter_next       = sym[cbh_pkg::LET_W-1:0];
                    prev_letter_valid_next = 1'b1;
                    par_let_next           = !par_let_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_pending_reg      <= 1'b0;
            lead_is_d1_reg        <= 1'b0;
            last_was_space_reg    <= 1'b0;
            prev_with_reg         <= '0;
            prev_with_valid_reg   <= 1'b0;
            par_with_reg          <= 1'b0;
            prev_letter_reg       <= '0;
            prev_letter_valid_reg <= 1'b0;
            par_let_reg           <= 1'b0;
        end else begin
            lead_pending_reg      <= lead_pending_next;
            lead_is_d1_reg        <= lead_is_d1_next;
            last_was_space_reg    <= last_was_space_next;
            prev_with_reg         <= prev_with_next;
            prev_with_valid_reg   <= prev_with_valid_next;
            par_with_reg          <= par_with_next;
            prev_letter_reg       <= prev_letter_next;
            prev_letter_valid_reg <= prev_letter_valid_next;
            par_let_reg           <= par_let_next;
        end
    end

    always_comb begin
        req.rd    = (op == cbh_pkg::OP_READ);
        req.rd_ok = ({1'b0, entry_index} < cbh_pkg::tbl_depth(table_select));
        req.sel   = table_select;
        req.inc   = '0;
        if (!req.rd && push) begin
            req.inc[cbh_pkg::TBL_SINGLE_WITH] = 1'b1;
            req.inc[cbh_pkg::TBL_OVL_WITH]    = prev_with_valid_reg;
            req.inc[cbh_pkg::TBL_NOVL_WITH]   = prev_with_valid_reg && par_with_reg;
            req.inc[cbh_pkg::TBL_SINGLE_LET]  = is_letter;
            req.inc[cbh_pkg::TBL_OVL_LET]     = is_letter && prev_letter_valid_reg;
            req.inc[cbh_pkg::TBL_NOVL_LET]    = is_letter && prev_letter_valid_reg
                                              && par_let_reg;
        end
        if (req.rd) begin
            for (int t = 0; t < cbh_pkg::NTBL; t++) begin
                req.addr[t] = entry_index;
            end
        end else begin
            req.addr[cbh_pkg::TBL_SINGLE_WITH] = cbh_pkg::IDX_W'(sym);
            req.addr[cbh_pkg::TBL_OVL_WITH]    = k_with;
            req.addr[cbh_pkg::TBL_NOVL_WITH]   = k_with;
            req.addr[cbh_pkg::TBL_SINGLE_LET]  = cbh_pkg::IDX_W'(sym[cbh_pkg::LET_W-1:0]);
            req.addr[cbh_pkg::TBL_OVL_LET]     = k_let;
            req.addr[cbh_pkg::TBL_NOVL_LET]    = k_let;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cbh_counters.sv @@
`default_nettype none

module cbh_counters (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         req_vld,
    input  wire cbh_pkg::cnt_req_t            req,
    input  wire logic                         clr_en,
    input  wire logic [cbh_pkg::IDX_W-1:0]    clr_addr,
    output logic                              rd_valid,
    output logic      [cbh_pkg::COUNT_W-1:0]  rd_data
);

    logic                        b_valid_reg, b_rd_reg, b_ok_reg;
    logic [cbh_pkg::SEL_W-1:0]   b_sel_reg;
    logic [cbh_pkg::COUNT_W-1:0] cur_vals [cbh_pkg::NTBL];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= req_vld;
        end
        b_rd_reg  <= req.rd;
        b_ok_reg  <= req.rd_ok;
        b_sel_reg <= req.sel;
    end

    for (genvar t = 0; t < cbh_pkg::NTBL; t++) begin : g_tbl
        localparam int unsigned DEPTH = cbh_pkg::TBL_DEPTH[t];
        localparam int unsigned AW    = $clog2(DEPTH);

        logic [AW-1:0]               raddr, waddr, b_addr_reg, fwd_addr_reg;
        logic [cbh_pkg::COUNT_W-1:0] rdata, cur, inc_val, wdata, fwd_data_reg;
        logic                        we, clr_hit, b_inc_reg, fwd_valid_reg;

        assign raddr = req.addr[t][AW-1:0];

        cbh_ram #(
            .DEPTH (DEPTH),
            .WIDTH (cbh_pkg::COUNT_W)
        ) u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (waddr),
            .wdata (wdata),
            .raddr (raddr),
            .rdata (rdata)
        );

        // the write of the previous cycle is not yet in rdata
        assign cur     = (fwd_valid_reg && fwd_addr_reg == b_addr_reg) ? fwd_data_reg : rdata;
        assign inc_val = (&cur) ? cur : cur + 1'b1;
        assign clr_hit = (clr_addr < cbh_pkg::IDX_W'(DEPTH));
        assign we      = clr_en ? clr_hit : b_inc_reg;
        assign waddr   = clr_en ? clr_addr[AW-1:0] : b_addr_reg;
        assign wdata   = clr_en ? '0 : inc_val;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                b_inc_reg     <= 1'b0;
                fwd_valid_reg <= 1'b0;
            end else begin
                b_inc_reg     <= req_vld && req.inc[t];
                fwd_valid_reg <= we;
            end
            b_addr_reg   <= raddr;
            fwd_addr_reg <= waddr;
            fwd_data_reg <= wdata;
        end

        assign cur_vals[t] = cur;
    end

    assign rd_valid = b_valid_reg && b_rd_reg;
    assign rd_data  = b_ok_reg ? cur_vals[b_sel_reg] : '0;

endmodule

`default_nettype wire

@@ rtl/cyrillic_letter_bigram_histogram.sv @@
// output: a read count is registered in stage b, then in the result queue
// throughput: one beat per cycle while s_tready is high, feeds and reads mixed,
//   each counter memory doing one read-modify-write per cycle with one-deep write forwarding
// reset: aresetn clears the decode state, then a sweep over addresses 0 to 1088
//   zeroes the counter memories one address per cycle; s_tready stays low during it
`default_nettype none

module cyrillic_letter_bigram_histogram (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // text_byte[7:0], table_select[10:8], entry_index[21:11]
    input  wire logic        s_tuser,   // op: 0 feed text byte, 1 read counter
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // count_value[31:0]
);

    // beat fields
    logic [7:0]                   text_byte;
    logic [cbh_pkg::SEL_W-1:0]    table_select;
    logic [cbh_pkg::IDX_W-1:0]    entry_index;
    logic                         acc;

    assign text_byte    = s_tdata[7:0];
    assign table_select = s_tdata[10:8];
    assign entry_index  = s_tdata[21:11];
    assign acc          = s_tvalid && s_tready;

    // clearing sweep after reset
    logic                         clearing_reg, clearing_next;
    logic [cbh_pkg::IDX_W-1:0]    clr_addr_reg, clr_addr_next;

    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == cbh_pkg::IDX_W'(cbh_pkg::CLR_LEN - 1)) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // stage a: utf-8 decode and symbol streams, builds the memory addresses
    cbh_pkg::cnt_req_t req;

    cbh_decode u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .acc          (acc),
        .op           (s_tuser),
        .text_byte    (text_byte),
        .table_select (table_select),
        .entry_index  (entry_index),
        .req          (req)
    );

    // stage b: read data back, saturating increment, write back or return
    logic                         rd_valid;
    logic [cbh_pkg::COUNT_W-1:0]  rd_data;

    cbh_counters u_counters (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_vld  (acc),
        .req      (req),
        .clr_en   (clearing_reg),
        .clr_addr (clr_addr_reg),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    // two-entry result queue, room is kept for the beat still in stage b
    logic [cbh_pkg::COUNT_W-1:0]  fifo_data_reg [2];
    logic [1:0]                   count_reg, count_next;
    logic                         rd_ptr_reg, wr_ptr_reg;
    logic                         push, pop;
    logic [2:0]                   occ_next;

    assign push     = rd_valid;
    assign pop      = m_tvalid && m_tready;
    assign occ_next = 3'(count_reg) + 3'(push) - 3'(pop);
    assign s_tready = !clearing_reg && (occ_next <= 3'd1);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
        if (push) begin
            fifo_data_reg[wr_ptr_reg] <= rd_data;
        end
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = fifo_data_reg[rd_ptr_reg];

endmodule

`default_nettype wire

@@ dv/cyrillic_letter_bigram_histogram_test.sv @@
`default_nettype none

module cyrillic_letter_bigram_histogram_test;

    timeunit 1ns;
    timeprecision 1ps;

    // selector codes outside the six tables, they read as zero
    localparam logic [cbh_pkg::SEL_W-1:0] SEL_SPARE_LO = 3'd6;
    localparam logic [cbh_pkg::SEL_W-1:0] SEL_SPARE_HI = 3'd7;

    localparam int unsigned N_ITEMS    = 1650;
    localparam int unsigned HOLD_AT    = 400;   // item count where the long hold-off starts
    localparam int unsigned HOLD_LEN   = 200;   // cycles the result side stays stalled
    localparam int unsigned BURST_LEN  = 40;    // reads offered back to back during the hold
    localparam int unsigned CALM_FROM  = 700;   // stretch with no idling on either side
    localparam int unsigned CALM_TO    = 900;
    localparam int unsigned DRAIN_AT   = 1200;  // sender pauses until all counts are back
    localparam int unsigned TAIL_WAIT  = 8;

    // ------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata  = '0;   // text_byte[7:0], table_select[10:8], entry_index[21:11]
    logic                s_tuser  = 1'b0; // op
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;         // count_value[31:0]

    initial begin
        forever #2 aclk = ~aclk;
    end

    cyrillic_letter_bigram_histogram u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------
    // histogram predictor
    // ------------------------------------------------------------------
    logic [cbh_pkg::COUNT_W-1:0] hist [cbh_pkg::NTBL][cbh_pkg::CLR_LEN];

    logic                      lead_wait;    // a lead byte is waiting for its second byte
    logic                      lead_d1;
    logic                      after_space;  // last symbol pushed was a space
    logic [cbh_pkg::SYM_W-1:0] with_prev;
    logic                      with_seen;
    logic                      with_odd;     // next symbol sits at an odd stream position
    logic [cbh_pkg::LET_W-1:0] let_prev;
    logic                      let_seen;
    logic                      let_odd;

    // most recent pair indexes, used to aim reads at live counters
    int unsigned last_pair_with;
    int unsigned last_pair_let;

    logic [cbh_pkg::COUNT_W-1:0] expected_counts [$];

    int unsigned n_items;
    int unsigned n_fail;

    logic        tx_idle = 1'b1;  // sender draws random gaps
    logic        rx_idle = 1'b1;  // receiver draws random stalls
    int unsigned hold_cycles = 0; // long stall requested of the receiver

    function automatic void clear_histogram();
        for (int t = 0; t < cbh_pkg::NTBL; t++)
            for (int k = 0; k < cbh_pkg::CLR_LEN; k++)
                hist[t][k] = '0;
        lead_wait   = 1'b0;
        lead_d1     = 1'b0;
        after_space = 1'b0;
        with_prev   = '0;
        with_seen   = 1'b0;
        with_odd    = 1'b0;
        let_prev    = '0;
        let_seen    = 1'b0;
        let_odd     = 1'b0;
        last_pair_with = 0;
        last_pair_let  = 0;
    endfunction

    // saturating increment
    function automatic void bump(input int t, input int unsigned k);
        if (hist[t][k] != '1)
            hist[t][k] = hist[t][k] + 1'b1;
    endfunction

    // letter code of a two-byte sequence, -1 when it is no russian letter
    function automatic int letter_code(input logic d1, input logic [7:0] b);
        if (!d1) begin
            if (b >= 8'h90 && b <= 8'hAF) return int'(b) - 'h90;
            if (b >= 8'hB0 && b <= 8'hBF) return int'(b) - 'hB0;
            if (b == cbh_pkg::YO_UPPER) return int'(cbh_pkg::YE_CODE);
        end else begin
            if (b >= 8'h80 && b <= 8'h8F) return int'(b) - 'h80 + 16;
            if (b == cbh_pkg::YO_LOWER) return int'(cbh_pkg::YE_CODE);
        end
        return -1;
    endfunction

    function automatic void emit_symbol(input logic [cbh_pkg::SYM_W-1:0] s);
        int unsigned k;
        // runs of spaces collapse to one
        if (s == cbh_pkg::SPACE_CODE && after_space)
            return;
        after_space = (s == cbh_pkg::SPACE_CODE);

        bump(cbh_pkg::TBL_SINGLE_WITH, s);
        if (with_seen) begin
            k = with_prev * cbh_pkg::NSYM_WITH + s;
            bump(cbh_pkg::TBL_OVL_WITH, k);
            if (with_odd)
                bump(cbh_pkg::TBL_NOVL_WITH, k);
            last_pair_with = k;
        end
        with_prev = s;
        with_seen = 1'b1;
        with_odd  = !with_odd;

        if (s < cbh_pkg::NSYM_LET) begin
            bump(cbh_pkg::TBL_SINGLE_LET, s);
            if (let_seen) begin
                k = let_prev * cbh_pkg::NSYM_LET + s;
                bump(cbh_pkg::TBL_OVL_LET, k);
                if (let_odd)
                    bump(cbh_pkg::TBL_NOVL_LET, k);
                last_pair_let = k;
            end
            let_prev = s[cbh_pkg::LET_W-1:0];
            let_seen = 1'b1;
            let_odd  = !let_odd;
        end
    endfunction

    function automatic void feed_text_byte(input logic [7:0] b);
        int code;
        if (lead_wait) begin
            // the lead always eats the next byte, decodable or not
            code = letter_code(lead_d1, b);
            lead_wait = 1'b0;
            if (code >= 0)
                emit_symbol(cbh_pkg::SYM_W'(code));
        end else if (b == cbh_pkg::LEAD_D0 || b == cbh_pkg::LEAD_D1) begin
            lead_wait = 1'b1;
            lead_d1   = (b == cbh_pkg::LEAD_D1);
        end else if (b == cbh_pkg::CH_SPACE || b == cbh_pkg::CH_TAB
                  || b == cbh_pkg::CH_LF || b == cbh_pkg::CH_CR) begin
            emit_symbol(cbh_pkg::SPACE_CODE);
        end
    endfunction

    function automatic logic [cbh_pkg::COUNT_W-1:0] lookup_count(
        input logic [cbh_pkg::SEL_W-1:0] sel,
        input logic [cbh_pkg::IDX_W-1:0] idx);
        if (sel > cbh_pkg::TBL_NOVL_LET)
            return '0;
        if (idx >= cbh_pkg::TBL_DEPTH[sel])
            return '0;
        return hist[sel][idx];
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // offer one beat, drive at the falling edge, accept at the rising edge
    task automatic push_beat(input cbh_pkg::op_t op, input logic [7:0] b,
                             input logic [cbh_pkg::SEL_W-1:0] sel,
                             input logic [cbh_pkg::IDX_W-1:0] idx,
                             input logic fixed, input logic [cbh_pkg::COUNT_W-1:0] fixed_val);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {idx, sel, b};
        do @(posedge aclk); while (!s_tready);
        // beat taken: a read expects one count, a feed moves the decoder
        if (op == cbh_pkg::OP_READ)
            expected_counts = {expected_counts, fixed ? fixed_val : lookup_count(sel, idx)};
        else
            feed_text_byte(b);
        n_items++;
    endtask

    // feed beat with random junk in the unused fields
    task automatic send_feed(input logic [7:0] b);
        push_beat(cbh_pkg::OP_FEED, b, cbh_pkg::SEL_W'($urandom), cbh_pkg::IDX_W'($urandom),
                  1'b0, '0);
    endtask

    task automatic send_letter(input int code);
        logic [7:0] lead;
        logic [7:0] second;
        if (code == int'(cbh_pkg::YE_CODE) && $urandom_range(0, 3) == 0) begin
            // yo in either case folds onto ye
            if ($urandom_range(0, 1) == 0) begin
                lead = cbh_pkg::LEAD_D0; second = cbh_pkg::YO_UPPER;
            end else begin
                lead = cbh_pkg::LEAD_D1; second = cbh_pkg::YO_LOWER;
            end
        end else if ($urandom_range(0, 1) == 0) begin
            // upper case, all under 0xD0
            lead = cbh_pkg::LEAD_D0; second = 8'(8'h90 + code);
        end else if (code < 16) begin
            lead = cbh_pkg::LEAD_D0; second = 8'(8'hB0 + code);
        end else begin
            lead = cbh_pkg::LEAD_D1; second = 8'(8'h80 + code - 16);
        end
        send_feed(lead);
        send_feed(second);
    endtask

    task automatic random_read();
        logic [cbh_pkg::SEL_W-1:0] sel;
        logic [cbh_pkg::IDX_W-1:0] idx;
        if ($urandom_range(0, 9) == 0)
            sel = cbh_pkg::SEL_W'($urandom_range(int'(SEL_SPARE_LO), int'(SEL_SPARE_HI)));
        else
            sel = cbh_pkg::SEL_W'($urandom_range(0, cbh_pkg::NTBL - 1));
        case ($urandom_range(0, 4))
            0, 1: begin
                // aim at the counter most likely to be live
                case (sel) inside
                    cbh_pkg::TBL_SINGLE_WITH:
                        idx = cbh_pkg::IDX_W'(with_prev);
                    cbh_pkg::TBL_OVL_WITH, cbh_pkg::TBL_NOVL_WITH:
                        idx = cbh_pkg::IDX_W'(last_pair_with);
                    cbh_pkg::TBL_SINGLE_LET:
                        idx = cbh_pkg::IDX_W'(let_prev);
                    cbh_pkg::TBL_OVL_LET, cbh_pkg::TBL_NOVL_LET:
                        idx = cbh_pkg::IDX_W'(last_pair_let);
                    default:
                        idx = cbh_pkg::IDX_W'($urandom);
                endcase
            end
            2, 3: begin
                if (sel <= cbh_pkg::TBL_NOVL_LET)
                    idx = cbh_pkg::IDX_W'($urandom_range(0, cbh_pkg::TBL_DEPTH[sel] - 1));
                else
                    idx = cbh_pkg::IDX_W'($urandom);
            end
            default: idx = cbh_pkg::IDX_W'($urandom);
        endcase
        push_beat(cbh_pkg::OP_READ, 8'($urandom), sel, idx, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // directed rows, fixed counts only where they are obvious
    // ------------------------------------------------------------------
    typedef struct packed {
        cbh_pkg::op_t              op;
        logic [7:0]                text;
        logic [cbh_pkg::SEL_W-1:0] sel;
        logic [cbh_pkg::IDX_W-1:0] idx;
        logic                      fixed;
        logic [31:0]               value;
    } stim_row_t;

    localparam int N_DIRECTED = 31;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // everything reads zero after reset, extremes of the index too
        '{cbh_pkg::OP_READ, 8'h00, cbh_pkg::TBL_SINGLE_WITH, 11'd0,    1'b1, 32'd0},
        '{cbh_pkg::OP_READ, 8'hFF, cbh_pkg::TBL_OVL_WITH,    11'd1088, 1'b1, 32'd0},
        '{cbh_pkg::OP_READ, 8'h00, cbh_pkg::TBL_NOVL_LET,    11'd1023, 1'b1, 32'd0},
        '{cbh_pkg::OP_READ, 8'h00, SEL_SPARE_HI,             11'd2047, 1'b1, 32'd0},
        // leading space is counted, the tab right after it collapses
        '{cbh_pkg::OP_FEED, cbh_pkg::CH_SPACE, 3'd0, 11'd0, 1'b0, 32'd0},
        '{cbh_pkg::OP_FEED, cbh_pkg::CH_TAB,   3'd0, 11'd0, 1'b0, 32'd0},
        // read in the middle of a two-byte letter
        '{cbh_pkg::OP_FEED, cbh_pkg::LEAD_D0,  3'd0, 11'd0, 1'b0, 32'd0},
        '{cbh_pkg::OP_READ, 8'h00, cbh_pkg::TBL_SINGLE_WITH, 11'd32, 1'b0, 32'd0},
        '{cbh_pkg::OP_FEED, 8'h90,             3'd0, 11'd0, 1'b0, 32'd0},   // first letter
        '{cbh_pkg::OP_FEED, cbh_pkg::LEAD_D1,  3'd0, 11'd0, 1'b0, 32'd0},
        '{cbh_pkg::OP_FEED, 8'h8F,             3'd0, 11'd0, 1'b0, 32'd0},   // last letter
        // yo in both cases counts as ye
        '{cbh_pkg::OP_FEED, cbh_pkg::LEAD_D0,  3'd0, 11'd0, 1'b0, 32'd0},
        '{cbh_pkg::OP_FEED, cbh_pkg::YO_UPPER, 3'd0, 11'd0, 1'b0, 32'd0},
        '{cbh_pkg::OP_FEED, cbh_pkg::LEAD_D1,  3'd0, 11'd0, 1'b0, 32'd0},
        '{cbh_pkg::OP_FEED, cbh_pkg::YO_LOWER, 3'd0, 11'd0, 1'b0, 32'd0},
        // lead eaten by a lead: pair dropped, nothing changes
        '{cbh_pkg::OP_FEED, cbh_pkg::LEAD_D0,  3'd0, 11'd0, 1'b0, 32'd0},
        '{cbh_pkg::OP_FEED, cbh_pkg::LEAD_D1,  3'd0, 11'd0, 1'b0, 32'd0},
        '{cbh_pkg::OP_FEED, cbh_pkg::CH_LF,    3'd0, 11'd0, 1'b0, 32'd0},
        // whitespace eaten by a lead, then cr collapses into the lf
        '{cbh_pkg::OP_FEED, cbh_pkg::LEAD_D1,  3'd0, 11'd0, 1'b0, 32'd0},
        '{cbh_pkg::OP_FEED, cbh_pkg::CH_CR,    3'd0, 11'd0, 1'b0, 32'd0},
        '{cbh_pkg::OP_FEED, cbh_pkg::CH_CR,    3'd0, 11'd0, 1'b0, 32'd0},
        '{cbh_pkg::OP_FEED, 8'h00,             3'd7, 11'd2047, 1'b0, 32'd0}, // dropped byte
        '{cbh_pkg::OP_FEED, cbh_pkg::LEAD_D0,  3'd0, 11'd0, 1'b0, 32'd0},
        '{cbh_pkg::OP_FEED, 8'hBF,             3'd0, 11'd0, 1'b0, 32'd0},
        // four of the tables once
        '{cbh_pkg::OP_READ, 8'h00, cbh_pkg::TBL_OVL_WITH,   11'd1071, 1'b0, 32'd0},
        '{cbh_pkg::OP_READ, 8'h00, cbh_pkg::TBL_OVL_LET,    11'd165,  1'b0, 32'd0},   // ye ye
        '{cbh_pkg::OP_READ, 8'h00, cbh_pkg::TBL_NOVL_LET,   11'd31,   1'b0, 32'd0},
        '{cbh_pkg::OP_READ, 8'h00, cbh_pkg::TBL_SINGLE_LET, 11'd5,    1'b0, 32'd0},
        // out of range indexes and the spare selector read zero
        '{cbh_pkg::OP_READ, 8'h00, cbh_pkg::TBL_SINGLE_LET, 11'd32,   1'b1, 32'd0},
        '{cbh_pkg::OP_READ, 8'h00, cbh_pkg::TBL_NOVL_WITH,  11'd1089, 1'b1, 32'd0},
        '{cbh_pkg::OP_READ, 8'h00, SEL_SPARE_LO,            11'd0,    1'b1, 32'd0}
    };

    // ------------------------------------------------------------------
    // result side: random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int unsigned gap;
        logic [cbh_pkg::COUNT_W-1:0] want;
        forever begin
            gap = rx_idle ? $urandom_range(0, 7) : 0;
            if (hold_cycles != 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            @(negedge aclk);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (expected_counts.size() == 0) begin
                $error("count_value: unexpected beat, actual %0d", m_tdata);
                n_fail++;
            end else begin
                want = expected_counts.pop_front();
                if (m_tdata !== want) begin
                    $error("count_value: expected %0d, actual %0d", want, m_tdata);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned r;
        logic held;
        logic drained;
        n_items     = 0;
        n_fail      = 0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        hold_cycles = 0;
        held        = 1'b0;
        drained     = 1'b0;
        clear_histogram();

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        // the clearing sweep keeps s_tready low, push_beat waits it out

        for (int i = 0; i < N_DIRECTED; i++)
            push_beat(DIRECTED[i].op, DIRECTED[i].text, DIRECTED[i].sel, DIRECTED[i].idx,
                      DIRECTED[i].fixed, DIRECTED[i].value);

        while (n_items < N_ITEMS) begin
            // output stalled for a long time while reads keep coming
            if (!held && n_items >= HOLD_AT) begin
                held = 1'b1;
                hold_cycles = HOLD_LEN;
                tx_idle = 1'b0;
                repeat (BURST_LEN) random_read();
                tx_idle = 1'b1;
            end
            tx_idle = !(n_items >= CALM_FROM && n_items < CALM_TO);
            rx_idle = tx_idle;
            // sender goes quiet until every count is back
            if (!drained && n_items >= DRAIN_AT) begin
                drained = 1'b1;
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (expected_counts.size() != 0) @(posedge aclk);
            end

            r = $urandom_range(0, 99);
            if (r < 55) begin
                // small alphabet half the time so pairs repeat
                if ($urandom_range(0, 1) == 0)
                    send_letter($urandom_range(0, 3));
                else
                    send_letter($urandom_range(0, cbh_pkg::NSYM_LET - 1));
            end else if (r < 68) begin
                case ($urandom_range(0, 3))
                    0: send_feed(cbh_pkg::CH_SPACE);
                    1: send_feed(cbh_pkg::CH_TAB);
                    2: send_feed(cbh_pkg::CH_LF);
                    default: send_feed(cbh_pkg::CH_CR);
                endcase
            end else if (r < 88) begin
                random_read();
            end else if (r < 94) begin
                // lead followed by anything
                send_feed($urandom_range(0, 1) ? cbh_pkg::LEAD_D1 : cbh_pkg::LEAD_D0);
                send_feed(8'($urandom));
            end else begin
                send_feed(8'($urandom));
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);

        if (n_fail == 0)
            $display("** cyrillic_letter_bigram_histogram: PASSED **");
        else
            $display("** cyrillic_letter_bigram_histogram: FAILED **");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("** cyrillic_letter_bigram_histogram: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
